FILE: hw/rtl/bss_pkg.sv
// package for the byte substring search core: types and constants
`timescale 1ns / 1ps
package bss_pkg;

   localparam int PATTERN_MAX_DEF = 16;
   localparam longint unsigned HAYSTACK_MAX_DEF = 64'd65536;

   localparam int LEN_W   = 5;
   localparam int POS_W   = 16;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 64;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_beat_type;

   typedef struct packed {
      logic             match_here;
      logic             found;
      logic [POS_W-1:0] first_offset;
      logic             done_res;
      logic             overflow;
   } rsp_beat_type;

   typedef struct packed {
      logic [LEN_W-1:0] pattern_length;
      logic [63:0]      pattern_bytes_low;
      logic [63:0]      pattern_bytes_high;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } win_ctrl_type;

endpackage

FILE: hw/rtl/bss_csr.sv
// register block holding the needle length and needle bytes
`timescale 1ns / 1ps
module bss_csr
   import bss_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready,
   output cfg_type           cfg
);

   typedef enum logic [1:0] {
      REG_PATTERN_LENGTH = 2'd0,
      REG_PATTERN_LOW    = 2'd1,
      REG_PATTERN_HIGH   = 2'd2,
      REG_NONE           = 2'd3
   } reg_index_type;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          wr_en;

   assign reg_index  = reg_index_type'(csr_paddr[ADDR_W-1:3]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_PATTERN_LENGTH: cfg_in.pattern_length     = csr_pwdata[LEN_W-1:0];
            REG_PATTERN_LOW:    cfg_in.pattern_bytes_low  = csr_pwdata;
            REG_PATTERN_HIGH:   cfg_in.pattern_bytes_high = csr_pwdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_PATTERN_LENGTH: csr_prdata = {{(DATA_W-LEN_W){1'b0}}, cfg_ff.pattern_length};
         REG_PATTERN_LOW:    csr_prdata = cfg_ff.pattern_bytes_low;
         REG_PATTERN_HIGH:   csr_prdata = cfg_ff.pattern_bytes_high;
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/bss_cell.sv
// one window cell: compares its incoming byte with its needle byte and holds it
`timescale 1ns / 1ps
module bss_cell
   import bss_pkg::*;
#(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  win_ctrl_type     ctrl,
   input  cfg_type          cfg,
   input  logic [LEN_W-1:0] len,
   input  logic [7:0]       byte_in,
   output logic [7:0]       byte_out,
   output logic             eq
);

   localparam logic [6:0] IDX_V = 7'(IDX);

   logic [7:0]       byte_ff;
   logic [7:0]       byte_nx_in;
   logic [LEN_W-1:0] sel;
   logic [7:0]       needle;
   logic             active;

   assign active = IDX_V < {2'b00, len};
   assign sel    = len - LEN_W'(1) - LEN_W'(IDX);

   // needle bytes past the sixteenth read as zero
   always_comb begin
      unique case (sel[4:3])
         2'b00:   needle = cfg.pattern_bytes_low[{sel[2:0], 3'b000} +: 8];
         2'b01:   needle = cfg.pattern_bytes_high[{sel[2:0], 3'b000} +: 8];
         default: needle = 8'h00;
      endcase
   end

   assign eq       = !active || (byte_in == needle);
   assign byte_out = byte_ff;

   always_comb begin
      byte_nx_in = byte_ff;
      if (ctrl.clear) begin
         byte_nx_in = 8'h00;
      end else if (ctrl.shift) begin
         byte_nx_in = byte_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'h00;
      end else begin
         byte_ff <= byte_nx_in;
      end
   end

endmodule

FILE: hw/rtl/byte_substring_search_core.sv
// top level of the streaming byte substring search core
//
//  channel | direction | handshake         | beat
//  req     | in        | req_valid/stall   | req_beat_type: data_byte, last_byte
//  rsp     | out       | rsp_valid/stall   | rsp_beat_type: match, found, offset, done, ovf
//  csr     | in        | apb, pready = 1   | 64-bit registers at 8*i
//
// one byte per cycle sustained while the result channel is not stalled
// an accepted beat is registered in the compare stage of the cell row, then in the output register
// synchronous active-high reset clears window, counters and valids; config registers to zero
// a stalled result holds the output register; the compare stage still takes a beat only while it is empty
`timescale 1ns / 1ps
module byte_substring_search_core
   import bss_pkg::*;
#(
   parameter int              PATTERN_MAX  = PATTERN_MAX_DEF,
   parameter longint unsigned HAYSTACK_MAX = HAYSTACK_MAX_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_beat_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_beat_type      rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam longint unsigned LIM = (HAYSTACK_MAX > 64'd65536) ? 64'd65536 :
                                     ((HAYSTACK_MAX == 64'd0) ? 64'd1 : HAYSTACK_MAX);
   localparam logic [POS_W:0]   LIM_V  = (POS_W+1)'(LIM);
   localparam logic [POS_W-1:0] POS_MAX = POS_W'(LIM - 64'd1);

   cfg_type          cfg;
   logic [LEN_W-1:0] len;
   win_ctrl_type     win_ctrl;
   logic [7:0]       link [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] cell_eq;

   logic accept;
   logic out_ready;
   logic a_ready;
   logic a_move;

   // compare stage
   logic                   a_valid_ff, a_valid_in;
   logic [PATTERN_MAX-1:0] a_eq_ff;
   logic                   a_elig_ff;
   logic                   a_len_zero_ff;
   logic [POS_W-1:0]       a_offset_ff;
   logic                   a_last_ff;
   logic                   a_ovf_ff;

   // haystack position
   logic [POS_W:0]   cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             full;
   logic             ovf_now;
   logic [POS_W-1:0] pos;
   logic             elig;

   // result stage
   logic             seen_ff, seen_in;
   logic [POS_W-1:0] first_ff, first_in;
   logic             hit;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_ff, rsp_in;

   bss_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign len = ({2'b00, cfg.pattern_length} > 7'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                                 : cfg.pattern_length;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || out_ready;
   assign a_move    = a_valid_ff && out_ready;
   assign req_stall = !a_ready;
   assign accept    = req_valid && a_ready;

   assign win_ctrl.shift = accept;
   assign win_ctrl.clear = accept && req_data.last_byte;

   assign link[0] = req_data.data_byte;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      if (k < PATTERN_MAX - 1) begin : g_mid
         bss_cell #(.IDX(k)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (win_ctrl),
            .cfg      (cfg),
            .len      (len),
            .byte_in  (link[k]),
            .byte_out (link[k+1]),
            .eq       (cell_eq[k])
         );
      end else begin : g_end
         bss_cell #(.IDX(k)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (win_ctrl),
            .cfg      (cfg),
            .len      (len),
            .byte_in  (link[k]),
            .byte_out (),
            .eq       (cell_eq[k])
         );
      end
   end

   // position saturates at the limit and raises overflow
   always_comb begin
      full    = cnt_ff >= LIM_V;
      ovf_now = ovf_ff || full;
      pos     = full ? POS_MAX : cnt_ff[POS_W-1:0];
      elig    = (({1'b0, pos} + (POS_W+1)'(1)) >= (POS_W+1)'(len)) || ovf_now;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            cnt_in = full ? cnt_ff : cnt_ff + (POS_W+1)'(1);
            ovf_in = ovf_now;
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (a_ready) begin
         a_valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_eq_ff       <= cell_eq;
         a_elig_ff     <= elig;
         a_len_zero_ff <= (len == '0);
         a_offset_ff   <= pos + POS_W'(1) - POS_W'(len);
         a_last_ff     <= req_data.last_byte;
         a_ovf_ff      <= ovf_now;
      end
   end

   // first match tracking and result register
   always_comb begin
      hit          = a_elig_ff && !a_len_zero_ff && (&a_eq_ff);
      seen_in      = seen_ff;
      first_in     = first_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (out_ready) begin
         rsp_valid_in = a_valid_ff;
      end
      if (a_move) begin
         if (a_len_zero_ff) begin
            seen_in = 1'b1;
         end else if (hit && !seen_ff) begin
            seen_in  = 1'b1;
            first_in = a_offset_ff;
         end
         rsp_in.match_here   = hit;
         rsp_in.found        = seen_in;
         rsp_in.first_offset = seen_in ? first_in : '0;
         rsp_in.done_res     = a_last_ff;
         rsp_in.overflow     = a_ovf_ff;
         if (a_last_ff) begin
            seen_in  = 1'b0;
            first_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         seen_ff      <= 1'b0;
         first_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_match_implies_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.match_here |-> rsp_data.found)
      else $error("match reported without found");

   a_offset_zero_when_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data.first_offset == '0)
      else $error("offset set while nothing found");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with room in the pipeline");

   a_last_clears_position: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.last_byte |=> cnt_ff == '0 && !ovf_ff)
      else $error("position not cleared after last beat");

endmodule

FILE: bench/tb_byte_substring_search_core.sv
// testbench for byte_substring_search_core: directed and random haystacks checked by a scoreboard
`timescale 1ns / 1ps
module tb_byte_substring_search_core;
   import bss_pkg::*;

   localparam int NEEDLE_MAX  = PATTERN_MAX_DEF;
   localparam int POS_LIMIT   = (HAYSTACK_MAX_DEF > 65536) ? 65536 : int'(HAYSTACK_MAX_DEF);
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_BYTES = 1350;

   typedef enum int {
      REG_PATTERN_LENGTH = 0,
      REG_PATTERN_LOW    = 1,
      REG_PATTERN_HIGH   = 2,
      REG_UNUSED         = 3
   } csr_index_type;

   class search_result_board;
      bit [LEN_W-1:0] pat_len;
      bit [63:0]      pat_low;
      bit [63:0]      pat_high;
      bit [7:0]       window [NEEDLE_MAX-1];
      int unsigned    position;
      bit             seen;
      bit [POS_W-1:0] first_start;
      bit             too_long;
      rsp_beat_type   awaited_results [$];
      int             errors;

      function new();
         clear_haystack();
      endfunction

      function void clear_haystack();
         foreach (window[i]) window[i] = 8'h00;
         position    = 0;
         seen        = 1'b0;
         first_start = '0;
         too_long    = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, bit [63:0] value);
         case (idx)
            REG_PATTERN_LENGTH: pat_len  = value[LEN_W-1:0];
            REG_PATTERN_LOW:    pat_low  = value;
            REG_PATTERN_HIGH:   pat_high = value;
            default: ;
         endcase
      endfunction

      function bit [7:0] needle_at(int i);
         if (i < 8) return pat_low[8*i +: 8];
         return pat_high[8*(i-8) +: 8];
      endfunction

      // accepted beat: advance the haystack state and queue the result it owes
      function void take_byte(req_beat_type b);
         rsp_beat_type r;
         int len;
         int pos;
         int k;
         bit hit;
         len = (pat_len > NEEDLE_MAX) ? NEEDLE_MAX : int'(pat_len);
         if (position >= POS_LIMIT) begin
            too_long = 1'b1;
            pos = POS_LIMIT - 1;
         end else begin
            pos = position;
            position++;
         end
         hit = 1'b0;
         if (len == 0) begin
            if (!seen) begin
               seen = 1'b1;
               first_start = '0;
            end
         end else if (pos + 1 >= len || too_long) begin
            hit = (needle_at(len - 1) == b.data_byte);
            for (k = 1; k < len; k++)
               if (window[k-1] != needle_at(len - 1 - k)) hit = 1'b0;
            if (hit && !seen) begin
               seen = 1'b1;
               first_start = POS_W'(pos + 1 - len);
            end
         end
         for (k = NEEDLE_MAX - 2; k > 0; k--) window[k] = window[k-1];
         window[0] = b.data_byte;
         r.match_here   = hit;
         r.found        = seen;
         r.first_offset = seen ? first_start : '0;
         r.done_res     = b.last_byte;
         r.overflow     = too_long;
         awaited_results.push_back(r);
         if (b.last_byte) clear_haystack();
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(rsp_beat_type got);
         rsp_beat_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: result with none expected, actual %p", $time, got);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         compare_field("match_here", want.match_here, got.match_here);
         compare_field("found", want.found, got.found);
         compare_field("first_offset", want.first_offset, got.first_offset);
         compare_field("done_res", want.done_res, got.done_res);
         compare_field("overflow", want.overflow, got.overflow);
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_beat_type      req_data;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_beat_type      rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [ADDR_W-1:0] csr_paddr;
   logic [DATA_W-1:0] csr_pwdata;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   search_result_board board = new();
   int unsigned cycle_count = 0;
   bit          send_quiet = 1'b0;
   bit          fast_send = 1'b0;
   bit          hold_off_request = 1'b0;
   bit [7:0]    hay [$];
   bit [7:0]    needle [NEEDLE_MAX];
   int          eff_len;

   byte_substring_search_core u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      if (send_quiet || fast_send) return 0;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(25, 8);
   endfunction

   task automatic send_beat(input bit [7:0] d, input bit last);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= req_beat_type'(9'($urandom));
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{data_byte: d, last_byte: last};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.take_byte(req_data);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.awaited_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input bit [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_W'(8 * idx);
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      board.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic send_haystack(input int pause_at);
      int i;
      for (i = 0; i < hay.size(); i++) begin
         if (i == pause_at && i > 0) wait_idle();
         send_beat(hay[i], i == hay.size() - 1);
      end
   endtask

   task automatic load_needle(input int len_val);
      bit [63:0] low;
      bit [63:0] high;
      int i;
      for (i = 0; i < NEEDLE_MAX; i++) begin
         if (i < 8) low[8*i +: 8] = needle[i];
         else high[8*(i-8) +: 8] = needle[i];
      end
      csr_write(REG_PATTERN_LENGTH, {32'($urandom), 27'($urandom), 5'(len_val)});
      csr_write(REG_PATTERN_LOW, low);
      csr_write(REG_PATTERN_HIGH, high);
      eff_len = (len_val > NEEDLE_MAX) ? NEEDLE_MAX : len_val;
   endtask

   task automatic random_config();
      int r;
      int shape;
      int len_val;
      int i;
      r = $urandom_range(11);
      if (r == 0) len_val = 0;
      else if (r == 1) len_val = NEEDLE_MAX;
      else if (r == 2) len_val = $urandom_range(31, NEEDLE_MAX + 1);
      else len_val = $urandom_range(NEEDLE_MAX - 1, 1);
      shape = $urandom_range(15);
      for (i = 0; i < NEEDLE_MAX; i++) begin
         if (shape == 0) needle[i] = 8'h00;
         else if (shape == 1) needle[i] = 8'hFF;
         else if (shape < 9) needle[i] = 8'h61 + 8'($urandom_range(1));
         else needle[i] = 8'($urandom);
      end
      load_needle(len_val);
   endtask

   task automatic build_haystack(input int hl);
      int i;
      hay.delete();
      while (hay.size() < hl) begin
         if (eff_len > 0 && $urandom_range(3) == 0) begin
            for (i = 0; i < eff_len; i++)
               hay.push_back(($urandom_range(11) == 0) ? 8'($urandom) : needle[i]);
         end else if (eff_len > 0 && $urandom_range(9) < 7) begin
            hay.push_back(needle[$urandom_range(eff_len - 1)]);
         end else begin
            hay.push_back(8'($urandom));
         end
      end
      while (hay.size() > hl) void'(hay.pop_back());
   endtask

   // receiver: random stalls, quiet stretches and one long hold-off on request
   initial begin
      int stall_left = 0;
      int quiet_left = 0;
      int hold_left = 0;
      bit quiet = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_left = 80;
            hold_off_request = 1'b0;
         end
         if (quiet_left == 0) begin
            quiet = !quiet;
            quiet_left = $urandom_range(300, 50);
         end else begin
            quiet_left--;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!quiet && $urandom_range(3) == 0) begin
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 10) : $urandom_range(3, 1);
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
      end
   end

   initial begin
      int random_bytes = 0;
      int phase = 0;
      int n_hay;
      int hl;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      eff_len     = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty needle straight from reset
      hay = '{8'h00, 8'hFF};
      send_haystack(-1);
      wait_idle();

      // needle "abc": haystack shorter than needle, then repeated matches
      needle = '{default: 8'h00};
      needle[0] = 8'h61;
      needle[1] = 8'h62;
      needle[2] = 8'h63;
      load_needle(3);
      csr_write(REG_UNUSED, '1);
      hay = '{8'h61, 8'h62};
      send_haystack(-1);
      hay = '{8'h61, 8'h62, 8'h63, 8'h61, 8'h62, 8'h63};
      send_haystack(3);
      wait_idle();

      // oversized length clamps to a full zero needle
      needle = '{default: 8'h00};
      load_needle(31);
      hay.delete();
      repeat (NEEDLE_MAX) hay.push_back(8'h00);
      send_haystack(-1);

      while (random_bytes < RANDOM_BYTES) begin
         wait_idle();
         random_config();
         n_hay = $urandom_range(6, 1);
         repeat (n_hay) begin
            hl = ($urandom_range(9) == 0) ? $urandom_range(120, 41) : $urandom_range(40, 1);
            if (phase % 10 == 0) begin
               hl = 60;
               hold_off_request = 1'b1;
               fast_send = 1'b1;
            end
            send_quiet = ($urandom_range(4) == 0);
            build_haystack(hl);
            send_haystack((phase == 1 || $urandom_range(29) == 0) ?
                          $urandom_range(hl - 1) : -1);
            fast_send = 1'b0;
            random_bytes += hl;
            phase++;
         end
      end

      // two-byte needle found at the start of a short haystack
      wait_idle();
      needle = '{default: 8'h00};
      needle[0] = 8'($urandom);
      needle[1] = 8'($urandom);
      load_needle(2);
      hay = '{needle[0], needle[1], 8'h5A};
      send_haystack(-1);

      wait_idle();
      repeat (10) @(posedge clock);
      if (board.awaited_results.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time,
                  board.awaited_results.size());
         board.errors++;
      end
      if (board.errors == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

FILE: files.f
hw/rtl/bss_pkg.sv
hw/rtl/bss_csr.sv
hw/rtl/bss_cell.sv
hw/rtl/byte_substring_search_core.sv
bench/tb_byte_substring_search_core.sv
